// ===== hdl/presence_confirm_qualifier_unit_macros.svh =====
// Assertion helpers shared by the qualifier modules.
`ifndef PRESENCE_CONFIRM_QUALIFIER_UNIT_MACROS_SVH
`define PRESENCE_CONFIRM_QUALIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/pcq_pkg.sv =====
package pcq_pkg;

   // accumulator width in bits; the accumulators count ms
   localparam int TIME_BITS = 16;
   localparam int CFG_W     = 16;
   localparam int PROG_W    = 10;
   localparam int QUOT_W    = PROG_W;
   localparam int WIDE_W    = ((TIME_BITS > CFG_W) ? TIME_BITS : CFG_W) + 1;
   localparam int DIV_W     = ((TIME_BITS > CFG_W) ? TIME_BITS : CFG_W) + QUOT_W;
   localparam int CNT_W     = $clog2(QUOT_W);

   localparam int APB_DW    = 32;
   localparam int APB_AW    = 5;
   localparam int IDX_W     = APB_AW - 2;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [CFG_W-1:0]     cfg_word_type;
   typedef logic [PROG_W-1:0]    prog_type;

   localparam time_type     TIME_MAX     = '1;
   localparam prog_type     PROG_FULL    = PROG_W'(1000);
   localparam cfg_word_type ELAPSED_MAX  = CFG_W'(1000);
   localparam cfg_word_type INTERVAL_MIN = CFG_W'(50);
   localparam cfg_word_type REQUIRED_MIN = CFG_W'(100);

   typedef enum logic [1:0] {
      CMD_DETECT = 2'd0,
      CMD_ASSIST = 2'd1,
      CMD_REARM  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_code_type;

   typedef enum logic [IDX_W-1:0] {
      REG_DET_INTERVAL = IDX_W'(0),
      REG_REQ_PRESENCE = IDX_W'(1),
      REG_REQ_ABSENCE  = IDX_W'(2),
      REG_DROPOUT      = IDX_W'(3),
      REG_AUTO_START   = IDX_W'(4)
   } reg_index_type;

   typedef struct packed {
      cfg_word_type detection_interval_ms;
      cfg_word_type required_presence_ms;
      cfg_word_type required_absence_ms;
      cfg_word_type dropout_grace_ms;
      logic         auto_start;
   } cfg_type;

   typedef struct packed {
      logic [1:0]   cmd;
      logic         frame_ok;
      logic         person_detected;
      cfg_word_type elapsed_ms;
      logic         assistant_present;
      logic         assistant_idle;
   } req_type;

   typedef struct packed {
      logic     raw_present;
      logic     locked;
      logic     presence_latched;
      prog_type progress_permille;
      logic     confirm_pulse;
      logic     rearm_pulse;
      logic     start_interaction;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic div_load;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic div_needed;
   } dp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } ctrl_state_type;

   function automatic time_type sat_add(time_type a, cfg_word_type d);
      logic [WIDE_W-1:0] s;
      s = WIDE_W'(a) + WIDE_W'(d);
      if (s > WIDE_W'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return s[TIME_BITS-1:0];
   endfunction

   function automatic logic time_ge(time_type t, cfg_word_type c);
      return WIDE_W'(t) >= WIDE_W'(c);
   endfunction

   function automatic logic time_gt(time_type t, cfg_word_type c);
      return WIDE_W'(t) > WIDE_W'(c);
   endfunction

   function automatic cfg_word_type floor_at(cfg_word_type v, cfg_word_type lo);
      return (v < lo) ? lo : v;
   endfunction

endpackage

// ===== hdl/pcq_req_if.sv =====
interface pcq_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic                frame_ok;
   logic                person_detected;
   pcq_pkg::cfg_word_type elapsed_ms;
   logic                assistant_present;
   logic                assistant_idle;

   modport source (
      output valid, cmd, frame_ok, person_detected, elapsed_ms,
             assistant_present, assistant_idle,
      input  ready
   );

   modport sink (
      input  valid, cmd, frame_ok, person_detected, elapsed_ms,
             assistant_present, assistant_idle,
      output ready
   );
endinterface

// ===== hdl/pcq_rsp_if.sv =====
interface pcq_rsp_if;
   logic               valid;
   logic               ready;
   logic               raw_present;
   logic               locked;
   logic               presence_latched;
   pcq_pkg::prog_type  progress_permille;
   logic               confirm_pulse;
   logic               rearm_pulse;
   logic               start_interaction;

   modport source (
      output valid, raw_present, locked, presence_latched, progress_permille,
             confirm_pulse, rearm_pulse, start_interaction,
      input  ready
   );

   modport sink (
      input  valid, raw_present, locked, presence_latched, progress_permille,
             confirm_pulse, rearm_pulse, start_interaction,
      output ready
   );
endinterface

// ===== hdl/pcq_regs.sv =====
module pcq_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pcq_pkg::APB_AW-1:0]   paddr,
   input  logic [pcq_pkg::APB_DW-1:0]   pwdata,
   output logic [pcq_pkg::APB_DW-1:0]   prdata,
   output logic                         pready,
   output pcq_pkg::cfg_type             cfg
);

   pcq_pkg::cfg_type         cfg_ff;
   pcq_pkg::cfg_type         cfg_in;
   logic [pcq_pkg::IDX_W-1:0] index;
   logic                     wr_en;

   assign pready = 1'b1;
   assign index  = paddr[pcq_pkg::APB_AW-1:2];
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            pcq_pkg::REG_DET_INTERVAL: begin
               cfg_in.detection_interval_ms = pwdata[pcq_pkg::CFG_W-1:0];
            end
            pcq_pkg::REG_REQ_PRESENCE: begin
               cfg_in.required_presence_ms = pwdata[pcq_pkg::CFG_W-1:0];
            end
            pcq_pkg::REG_REQ_ABSENCE: begin
               cfg_in.required_absence_ms = pwdata[pcq_pkg::CFG_W-1:0];
            end
            pcq_pkg::REG_DROPOUT: begin
               cfg_in.dropout_grace_ms = pwdata[pcq_pkg::CFG_W-1:0];
            end
            pcq_pkg::REG_AUTO_START: begin
               cfg_in.auto_start = pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         pcq_pkg::REG_DET_INTERVAL: prdata = pcq_pkg::APB_DW'(cfg_ff.detection_interval_ms);
         pcq_pkg::REG_REQ_PRESENCE: prdata = pcq_pkg::APB_DW'(cfg_ff.required_presence_ms);
         pcq_pkg::REG_REQ_ABSENCE:  prdata = pcq_pkg::APB_DW'(cfg_ff.required_absence_ms);
         pcq_pkg::REG_DROPOUT:      prdata = pcq_pkg::APB_DW'(cfg_ff.dropout_grace_ms);
         pcq_pkg::REG_AUTO_START:   prdata = pcq_pkg::APB_DW'(cfg_ff.auto_start);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detection_interval_ms <= pcq_pkg::CFG_W'(500);
         cfg_ff.required_presence_ms  <= pcq_pkg::CFG_W'(2000);
         cfg_ff.required_absence_ms   <= pcq_pkg::CFG_W'(3000);
         cfg_ff.dropout_grace_ms      <= pcq_pkg::CFG_W'(500);
         cfg_ff.auto_start            <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/pcq_ctrl.sv =====
`include "presence_confirm_qualifier_unit_macros.svh"

module pcq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  pcq_pkg::dp_status_type status,
   output pcq_pkg::dp_cmd_type    cmd
);

   pcq_pkg::ctrl_state_type    state_ff;
   pcq_pkg::ctrl_state_type    state_in;
   logic [pcq_pkg::CNT_W-1:0]  count_ff;
   logic [pcq_pkg::CNT_W-1:0]  count_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       out_free;
   logic                       last_step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (count_ff == pcq_pkg::CNT_W'(pcq_pkg::QUOT_W - 1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         pcq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = pcq_pkg::ST_PREP;
            end
         end
         pcq_pkg::ST_PREP: begin
            count_in = '0;
            if (status.div_needed) begin
               cmd.div_load = 1'b1;
               state_in     = pcq_pkg::ST_DIV;
            end else begin
               state_in = pcq_pkg::ST_FINISH;
            end
         end
         pcq_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (last_step) begin
               state_in = pcq_pkg::ST_FINISH;
            end
         end
         pcq_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pcq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PCQ_ASSERT_NEXT(a_accept_prep, clock, reset, req_valid && req_ready,
      state_ff == pcq_pkg::ST_PREP, "accepted beat did not enter prep")
   `PCQ_ASSERT_NEXT(a_div_end, clock, reset, state_ff == pcq_pkg::ST_DIV && last_step,
      state_ff == pcq_pkg::ST_FINISH, "divider did not finish after last step")
   `PCQ_ASSERT_NEXT(a_finish_out, clock, reset, state_ff == pcq_pkg::ST_FINISH && out_free,
      rsp_valid_ff && state_ff == pcq_pkg::ST_IDLE, "result not posted on finish")

endmodule

// ===== hdl/pcq_dp.sv =====
`include "presence_confirm_qualifier_unit_macros.svh"

module pcq_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pcq_pkg::cfg_type       cfg,
   input  pcq_pkg::req_type       req,
   input  pcq_pkg::dp_cmd_type    cmd,
   output pcq_pkg::dp_status_type status,
   output pcq_pkg::rsp_type       rsp
);

   pcq_pkg::time_type   presence_ff, presence_in;
   pcq_pkg::time_type   absence_ff, absence_in;
   pcq_pkg::prog_type   progress_ff, progress_in;
   logic                conf_ff, conf_in;
   logic                wait_ff, wait_in;
   logic                raw_ff, raw_in;
   logic                have_ts_ff, have_ts_in;
   logic                div_needed_ff, div_needed_in;
   logic [2:0]          pulse_ff, pulse_in;   // confirm, rearm, start
   pcq_pkg::rsp_type    out_ff;

   logic [pcq_pkg::DIV_W-1:0]  rem_ff, trial_ff;
   logic [pcq_pkg::QUOT_W-1:0] quot_ff;
   logic                       rem_ge;

   pcq_pkg::cfg_word_type delta, need, abs_need;
   logic                  busy, can_start, p_ge;

   assign need     = pcq_pkg::floor_at(cfg.required_presence_ms, pcq_pkg::REQUIRED_MIN);
   assign abs_need = pcq_pkg::floor_at(cfg.required_absence_ms, pcq_pkg::REQUIRED_MIN);
   assign busy      = req.assistant_present && !req.assistant_idle;
   assign can_start = req.assistant_present && req.assistant_idle;

   always_comb begin
      if (have_ts_ff) begin
         delta = (req.elapsed_ms > pcq_pkg::ELAPSED_MAX) ? pcq_pkg::ELAPSED_MAX
                                                        : req.elapsed_ms;
      end else begin
         delta = pcq_pkg::floor_at(cfg.detection_interval_ms, pcq_pkg::INTERVAL_MIN);
      end
   end

   // command update, evaluated on the accepted beat
   always_comb begin
      presence_in   = presence_ff;
      absence_in    = absence_ff;
      progress_in   = progress_ff;
      conf_in       = conf_ff;
      wait_in       = wait_ff;
      raw_in        = raw_ff;
      have_ts_in    = have_ts_ff;
      div_needed_in = 1'b0;
      pulse_in      = 3'b000;
      p_ge          = 1'b0;
      case (req.cmd)
         pcq_pkg::CMD_DETECT: begin
            have_ts_in = 1'b1;
            if (!req.frame_ok) begin
               raw_in      = 1'b0;
               presence_in = '0;
               progress_in = '0;
            end else begin
               raw_in = req.person_detected;
               if (busy) begin
                  wait_in     = 1'b1;
                  presence_in = '0;
                  absence_in  = '0;
                  progress_in = '0;
               end else if (wait_ff) begin
                  presence_in = '0;
                  progress_in = '0;
                  absence_in  = req.person_detected ? '0
                                : pcq_pkg::sat_add(absence_ff, delta);
                  if (pcq_pkg::time_ge(absence_in, abs_need)) begin
                     conf_in     = 1'b0;
                     wait_in     = 1'b0;
                     absence_in  = '0;
                     pulse_in[1] = 1'b1;
                  end
               end else begin
                  if (req.person_detected) begin
                     presence_in = pcq_pkg::sat_add(presence_ff, delta);
                     absence_in  = '0;
                  end else begin
                     absence_in = pcq_pkg::sat_add(absence_ff, delta);
                     if (pcq_pkg::time_gt(absence_in, cfg.dropout_grace_ms)) begin
                        presence_in = '0;
                     end
                  end
                  p_ge = pcq_pkg::time_ge(presence_in, need);
                  // below the target the ratio stays under 1000 and goes to the divider
                  if (p_ge) begin
                     progress_in = pcq_pkg::PROG_FULL;
                  end else begin
                     div_needed_in = 1'b1;
                  end
                  if (!conf_ff && p_ge && (!cfg.auto_start || can_start)) begin
                     conf_in     = 1'b1;
                     wait_in     = 1'b1;
                     pulse_in[0] = 1'b1;
                     pulse_in[2] = cfg.auto_start && can_start;
                  end
               end
            end
         end
         pcq_pkg::CMD_ASSIST: begin
            presence_in = '0;
            absence_in  = '0;
            progress_in = '0;
            if (!req.assistant_idle) begin
               wait_in = 1'b1;
            end else begin
               have_ts_in = 1'b1;
            end
         end
         pcq_pkg::CMD_REARM: begin
            if (!busy) begin
               pulse_in[1] = conf_ff || wait_ff;
               conf_in     = 1'b0;
               wait_in     = 1'b0;
               presence_in = '0;
               absence_in  = '0;
               progress_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presence_ff   <= '0;
         absence_ff    <= '0;
         progress_ff   <= '0;
         conf_ff       <= 1'b0;
         wait_ff       <= 1'b0;
         raw_ff        <= 1'b0;
         have_ts_ff    <= 1'b0;
         div_needed_ff <= 1'b0;
         pulse_ff      <= 3'b000;
      end else if (cmd.start) begin
         presence_ff   <= presence_in;
         absence_ff    <= absence_in;
         progress_ff   <= progress_in;
         conf_ff       <= conf_in;
         wait_ff       <= wait_in;
         raw_ff        <= raw_in;
         have_ts_ff    <= have_ts_in;
         div_needed_ff <= div_needed_in;
         pulse_ff      <= pulse_in;
      end else if (cmd.load_out && div_needed_ff) begin
         progress_ff <= quot_ff;
      end
   end

   // restoring divider: one quotient bit per step, MSB first
   assign rem_ge = (rem_ff >= trial_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff   <= pcq_pkg::DIV_W'(presence_ff) * pcq_pkg::DIV_W'(1000);
         trial_ff <= pcq_pkg::DIV_W'(need) << (pcq_pkg::QUOT_W - 1);
         quot_ff  <= '0;
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - trial_ff;
         end
         trial_ff <= trial_ff >> 1;
         quot_ff  <= {quot_ff[pcq_pkg::QUOT_W-2:0], rem_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (cmd.load_out) begin
         out_ff.raw_present       <= raw_ff;
         out_ff.locked            <= wait_ff;
         out_ff.presence_latched  <= conf_ff;
         out_ff.progress_permille <= div_needed_ff ? quot_ff : progress_ff;
         out_ff.confirm_pulse     <= pulse_ff[0];
         out_ff.rearm_pulse       <= pulse_ff[1];
         out_ff.start_interaction <= pulse_ff[2];
      end
   end

   assign status.div_needed = div_needed_ff;
   assign rsp               = out_ff;

   `PCQ_ASSERT_IMPL(a_prog_max, clock, reset, 1'b1,
      progress_ff <= pcq_pkg::PROG_FULL, "progress above full scale")
   `PCQ_ASSERT_IMPL(a_confirm_locks, clock, reset, out_ff.confirm_pulse,
      out_ff.locked && out_ff.presence_latched, "confirm without latch and lock")
   `PCQ_ASSERT_IMPL(a_start_confirm, clock, reset, out_ff.start_interaction,
      out_ff.confirm_pulse, "start without confirm")
   `PCQ_ASSERT_IMPL(a_rearm_unlocks, clock, reset, out_ff.rearm_pulse,
      !out_ff.locked && !out_ff.presence_latched, "rearm left block locked")

endmodule

// ===== hdl/presence_confirm_qualifier_unit.sv =====
// Flow: a request beat is accepted in idle and goes to prep; when a progress ratio is
//   needed it runs through the 10-step divider, and the finish step posts the response.
// Issue: a new request is accepted only once the previous response is posted; the serial
//   restoring divider gives one quotient bit per cycle; a held response beat stalls finish.
// Reset: synchronous, active high; clears accumulators, flags and the response
//   valid, and loads the registers with 500, 2000, 3000, 500 and auto_start set.
module presence_confirm_qualifier_unit (
   input  logic                         clock,
   input  logic                         reset,
   pcq_req_if.sink                      req_chan,
   pcq_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pcq_pkg::APB_AW-1:0]   paddr,
   input  logic [pcq_pkg::APB_DW-1:0]   pwdata,
   output logic [pcq_pkg::APB_DW-1:0]   prdata,
   output logic                         pready
);

   pcq_pkg::cfg_type       cfg;
   pcq_pkg::req_type       req;
   pcq_pkg::rsp_type       rsp;
   pcq_pkg::dp_cmd_type    dp_cmd;
   pcq_pkg::dp_status_type dp_status;

   // request payload is only sampled on the accepting edge (cmd.start)
   assign req.cmd               = req_chan.cmd;
   assign req.frame_ok          = req_chan.frame_ok;
   assign req.person_detected   = req_chan.person_detected;
   assign req.elapsed_ms        = req_chan.elapsed_ms;
   assign req.assistant_present = req_chan.assistant_present;
   assign req.assistant_idle    = req_chan.assistant_idle;

   // register file, APB writes complete in the access phase
   pcq_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: accept, prep, divide, finish
   pcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // qualifier state, divider and response register
   pcq_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req    (req),
      .cmd    (dp_cmd),
      .status (dp_status),
      .rsp    (rsp)
   );

   // response beat fields straight from the output register
   assign rsp_chan.raw_present       = rsp.raw_present;
   assign rsp_chan.locked            = rsp.locked;
   assign rsp_chan.presence_latched  = rsp.presence_latched;
   assign rsp_chan.progress_permille = rsp.progress_permille;
   assign rsp_chan.confirm_pulse     = rsp.confirm_pulse;
   assign rsp_chan.rearm_pulse       = rsp.rearm_pulse;
   assign rsp_chan.start_interaction = rsp.start_interaction;

endmodule
